[design/spi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spi_pkg;

  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_ONE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TWO = 2'd2;

  localparam int PT_W   = 18;
  localparam int PT_MAX = 131071;
  localparam int PT_MIN = -131072;

  typedef struct packed {
    logic hit;
    logic cop;
  } spi_flags_t;

endpackage
`default_nettype wire

[design/spi_div_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// one restoring division step for three lanes sharing a divisor
module spi_div_stage #(
  parameter int MW = 70,
  parameter int DW = 52,
  parameter int QB = 17,
  parameter int SH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [2:0][MW-1:0]     rem_in,
  input  wire logic [2:0][QB-1:0]     q_in,
  input  wire logic [DW-1:0]          den_in,
  output logic      [2:0][MW-1:0]     rem_r,
  output logic      [2:0][QB-1:0]     q_r,
  output logic      [DW-1:0]          den_r
);

  logic [MW-1:0]        den_sh;
  logic [2:0][MW:0]     diff;
  logic [2:0][MW-1:0]   rem_nxt;
  logic [2:0][QB-1:0]   q_nxt;

  always_comb begin
    den_sh = MW'(den_in) << SH;
    for (int k = 0; k < 3; k++) begin
      diff[k]    = {1'b0, rem_in[k]} - {1'b0, den_sh};
      rem_nxt[k] = diff[k][MW] ? rem_in[k] : diff[k][MW-1:0];
      q_nxt[k]   = q_in[k];
      q_nxt[k][SH] = !diff[k][MW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      den_r <= den_in;
    end
  end

endmodule
`default_nettype wire

[design/segment_parallelogram_intersect_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_start_*, in_end_*
// out     | output    | out_valid / out_ready | out_hit, out_coplanar, out_point_*
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one segment per cycle while out_ready keeps the pipeline moving; COORD_BITS + 6 register
// stages (17 bits of quotient at one restoring step per stage, plus cross, dot,
// sign, multiply and output stages).
// reset (rst_n low, synchronous) empties the pipeline and clears the configuration registers.
// each stage holds while the one after it is full and stalled, so bubbles
// still fill while a result waits on out_ready.
module segment_parallelogram_intersect_top #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_BITS-1:0]  in_start_x,
  input  wire logic signed [COORD_BITS-1:0]  in_start_y,
  input  wire logic signed [COORD_BITS-1:0]  in_start_z,
  input  wire logic signed [COORD_BITS-1:0]  in_end_x,
  input  wire logic signed [COORD_BITS-1:0]  in_end_y,
  input  wire logic signed [COORD_BITS-1:0]  in_end_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic                               out_coplanar,
  output logic signed [spi_pkg::PT_W-1:0]    out_point_x,
  output logic signed [spi_pkg::PT_W-1:0]    out_point_y,
  output logic signed [spi_pkg::PT_W-1:0]    out_point_z,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [spi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spi_pkg::CFG_W-1:0]     cfg_data
);

  localparam int C  = COORD_BITS;
  localparam int XW = 2 * C + 2;
  localparam int DW = 3 * C + 4;
  localparam int MW = DW + C + 1;
  localparam int QB = C + 1;
  localparam int FW = C + 3;
  localparam int LW = (3 * C > spi_pkg::CFG_W) ? 3 * C : spi_pkg::CFG_W;
  localparam int EW = (FW > spi_pkg::PT_W) ? FW : spi_pkg::PT_W;
  localparam int FI = QB + 4;
  localparam int NS = QB + 5;
  localparam logic signed [EW-1:0] P_MAX = EW'(spi_pkg::PT_MAX);
  localparam logic signed [EW-1:0] P_MIN = EW'(spi_pkg::PT_MIN);

  // configuration
  logic [spi_pkg::CFG_W-1:0] origin_r, edge_one_r, edge_two_r;
  logic [LW-1:0]             o_ext, a_ext, b_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r   <= '0;
      edge_one_r <= '0;
      edge_two_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == spi_pkg::CFG_ORIGIN)   origin_r   <= cfg_data;
      if (cfg_index == spi_pkg::CFG_EDGE_ONE) edge_one_r <= cfg_data;
      if (cfg_index == spi_pkg::CFG_EDGE_TWO) edge_two_r <= cfg_data;
    end
  end

  assign o_ext = LW'(origin_r);
  assign a_ext = LW'(edge_one_r);
  assign b_ext = LW'(edge_two_r);

  // pipeline control
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[FI];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: differences and cross products
  logic signed [C-1:0]  s_i [3];
  logic signed [C-1:0]  e_i [3];
  logic signed [C-1:0]  a_i [3];
  logic signed [C-1:0]  b_i [3];
  logic signed [C-1:0]  o_i [3];
  logic signed [XW-1:0] d_x [3];
  logic signed [XW-1:0] r_x [3];
  logic signed [XW-1:0] a_x [3];
  logic signed [XW-1:0] b_x [3];
  logic signed [XW-1:0] ab_nxt [3];
  logic signed [XW-1:0] rb_nxt [3];
  logic signed [XW-1:0] ar_nxt [3];

  logic [2:0][C-1:0]    s0_r;
  logic signed [C:0]    d0_r [3];
  logic signed [C:0]    r0_r [3];
  logic signed [XW-1:0] ab0_r [3];
  logic signed [XW-1:0] rb0_r [3];
  logic signed [XW-1:0] ar0_r [3];

  always_comb begin
    s_i[0] = in_start_x; s_i[1] = in_start_y; s_i[2] = in_start_z;
    e_i[0] = in_end_x;   e_i[1] = in_end_y;   e_i[2] = in_end_z;
    for (int k = 0; k < 3; k++) begin
      a_i[k] = $signed(a_ext[k*C +: C]);
      b_i[k] = $signed(b_ext[k*C +: C]);
      o_i[k] = $signed(o_ext[k*C +: C]);
      d_x[k] = XW'(e_i[k]) - XW'(s_i[k]);
      r_x[k] = XW'(o_i[k]) - XW'(s_i[k]);
      a_x[k] = XW'(a_i[k]);
      b_x[k] = XW'(b_i[k]);
    end
    for (int k = 0; k < 3; k++) begin
      ab_nxt[k] = a_x[(k+1)%3] * b_x[(k+2)%3] - a_x[(k+2)%3] * b_x[(k+1)%3];
      rb_nxt[k] = r_x[(k+1)%3] * b_x[(k+2)%3] - r_x[(k+2)%3] * b_x[(k+1)%3];
      ar_nxt[k] = a_x[(k+1)%3] * r_x[(k+2)%3] - a_x[(k+2)%3] * r_x[(k+1)%3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < 3; k++) begin
        s0_r[k]  <= s_i[k];
        d0_r[k]  <= d_x[k][C:0];
        r0_r[k]  <= r_x[k][C:0];
        ab0_r[k] <= ab_nxt[k];
        rb0_r[k] <= rb_nxt[k];
        ar0_r[k] <= ar_nxt[k];
      end
    end
  end

  // stage 1: determinants by dot products
  logic signed [DW-1:0] den_nxt, nt_nxt, nu_nxt, nv_nxt;
  logic [2:0][C-1:0]    s1_r;
  logic signed [C:0]    d1_r [3];
  logic signed [DW-1:0] den1_r, nt1_r, nu1_r, nv1_r;

  always_comb begin
    den_nxt = '0;
    nt_nxt  = '0;
    nu_nxt  = '0;
    nv_nxt  = '0;
    for (int k = 0; k < 3; k++) begin
      den_nxt = den_nxt + DW'(d0_r[k]) * DW'(ab0_r[k]);
      nt_nxt  = nt_nxt  + DW'(r0_r[k]) * DW'(ab0_r[k]);
      nu_nxt  = nu_nxt  - DW'(d0_r[k]) * DW'(rb0_r[k]);
      nv_nxt  = nv_nxt  - DW'(d0_r[k]) * DW'(ar0_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_r   <= s0_r;
      for (int k = 0; k < 3; k++) d1_r[k] <= d0_r[k];
      den1_r <= den_nxt;
      nt1_r  <= nt_nxt;
      nu1_r  <= nu_nxt;
      nv1_r  <= nv_nxt;
    end
  end

  // stage 2: sign fold, range checks, hit decision
  logic signed [DW-1:0] dn, tn, un, vn, dt, du, dv;
  logic                 den_z, nt_z, in_range;
  spi_pkg::spi_flags_t  flags_nxt;
  logic [2:0][C:0]      dmag_nxt;
  logic [2:0]           dneg_nxt;

  logic [2:0][C-1:0]    s2_r;
  logic [2:0][C:0]      dmag2_r;
  logic [2:0]           dneg2_r;
  logic [DW-1:0]        den2_r, nt2_r;
  spi_pkg::spi_flags_t  flags2_r;

  always_comb begin
    den_z = (den1_r == '0);
    nt_z  = (nt1_r == '0);
    dn = den1_r[DW-1] ? -den1_r : den1_r;
    tn = den1_r[DW-1] ? -nt1_r  : nt1_r;
    un = den1_r[DW-1] ? -nu1_r  : nu1_r;
    vn = den1_r[DW-1] ? -nv1_r  : nv1_r;
    dt = dn - tn;
    du = dn - un;
    dv = dn - vn;
    in_range = !tn[DW-1] && !dt[DW-1] && !un[DW-1] && !du[DW-1]
               && !vn[DW-1] && !dv[DW-1];
    flags_nxt.cop = den_z && nt_z;
    flags_nxt.hit = (den_z && nt_z) || (!den_z && in_range);
    for (int k = 0; k < 3; k++) begin
      dneg_nxt[k] = d1_r[k][C];
      dmag_nxt[k] = d1_r[k][C] ? -d1_r[k] : d1_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_r     <= s1_r;
      dmag2_r  <= dmag_nxt;
      dneg2_r  <= dneg_nxt;
      den2_r   <= dn;
      nt2_r    <= tn;
      flags2_r <= flags_nxt;
    end
  end

  // stage 3: dividends |d| * nt
  logic [2:0][MW-1:0]  m3_r;
  logic [DW-1:0]       den3_r;
  logic [2:0][C-1:0]   s3_r;
  logic [2:0]          dneg3_r;
  spi_pkg::spi_flags_t flags3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 3; k++) m3_r[k] <= MW'(dmag2_r[k]) * MW'(nt2_r);
      den3_r   <= den2_r;
      s3_r     <= s2_r;
      dneg3_r  <= dneg2_r;
      flags3_r <= flags2_r;
    end
  end

  // stages 4..: one quotient bit per stage
  logic [2:0][MW-1:0]  rem_a   [QB+1];
  logic [2:0][QB-1:0]  q_a     [QB+1];
  logic [DW-1:0]       den_a   [QB+1];
  logic [2:0][C-1:0]   s_a     [QB+1];
  logic [2:0]          dneg_a  [QB+1];
  spi_pkg::spi_flags_t flags_a [QB+1];

  assign rem_a[0]   = m3_r;
  assign q_a[0]     = '0;
  assign den_a[0]   = den3_r;
  assign s_a[0]     = s3_r;
  assign dneg_a[0]  = dneg3_r;
  assign flags_a[0] = flags3_r;

  for (genvar j = 0; j < QB; j++) begin : g_div
    spi_div_stage #(
      .MW(MW),
      .DW(DW),
      .QB(QB),
      .SH(QB - 1 - j)
    ) u_stage (
      .clk    (clk),
      .en     (adv[4+j]),
      .rem_in (rem_a[j]),
      .q_in   (q_a[j]),
      .den_in (den_a[j]),
      .rem_r  (rem_a[j+1]),
      .q_r    (q_a[j+1]),
      .den_r  (den_a[j+1])
    );

    logic [2:0][C-1:0]   s_r;
    logic [2:0]          dneg_r;
    spi_pkg::spi_flags_t flags_r;

    always_ff @(posedge clk) begin
      if (adv[4+j]) begin
        s_r     <= s_a[j];
        dneg_r  <= dneg_a[j];
        flags_r <= flags_a[j];
      end
    end

    assign s_a[j+1]     = s_r;
    assign dneg_a[j+1]  = dneg_r;
    assign flags_a[j+1] = flags_r;
  end

  // final stage: floor to truncation, clamp, select
  logic signed [FW-1:0] qx   [3];
  logic signed [FW-1:0] fq   [3];
  logic signed [FW-1:0] xs   [3];
  logic signed [FW-1:0] res  [3];
  logic signed [EW-1:0] xe   [3];
  logic signed [EW-1:0] cl   [3];
  logic                 remnz [3];
  logic [spi_pkg::PT_W-1:0] pt_nxt [3];

  logic                     hit_r, cop_r;
  logic [spi_pkg::PT_W-1:0] pt_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      remnz[k] = |rem_a[QB][k];
      qx[k]    = $signed({2'b00, q_a[QB][k]});
      // negative direction: floor of -q - frac
      fq[k]    = dneg_a[QB][k] ? (-qx[k] - FW'(remnz[k])) : qx[k];
      xs[k]    = fq[k] + FW'($signed(s_a[QB][k]));
      res[k]   = xs[k] + FW'(remnz[k] && xs[k][FW-1]);
      xe[k]    = EW'(res[k]);
      if (xe[k] > P_MAX) begin
        cl[k] = P_MAX;
      end else if (xe[k] < P_MIN) begin
        cl[k] = P_MIN;
      end else begin
        cl[k] = xe[k];
      end
      if (flags_a[QB].cop) begin
        pt_nxt[k] = spi_pkg::PT_W'($signed(s_a[QB][k]));
      end else if (flags_a[QB].hit) begin
        pt_nxt[k] = cl[k][spi_pkg::PT_W-1:0];
      end else begin
        pt_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[FI]) begin
      hit_r <= flags_a[QB].hit;
      cop_r <= flags_a[QB].cop;
      for (int k = 0; k < 3; k++) pt_r[k] <= pt_nxt[k];
    end
  end

  assign out_hit      = hit_r;
  assign out_coplanar = cop_r;
  assign out_point_x  = $signed(pt_r[0]);
  assign out_point_y  = $signed(pt_r[1]);
  assign out_point_z  = $signed(pt_r[2]);

endmodule
`default_nettype wire

[tb/tb_segment_parallelogram_intersect_top.sv]
`timescale 1ns / 1ps
module tb_segment_parallelogram_intersect_top;

  localparam int COORD_W   = 16;
  localparam int LATENCY   = COORD_W + 6;
  localparam int WDOG_MAX  = 5000;
  localparam logic [spi_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic hit;
    logic cop;
    logic signed [spi_pkg::PT_W-1:0] px;
    logic signed [spi_pkg::PT_W-1:0] py;
    logic signed [spi_pkg::PT_W-1:0] pz;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_start_x = '0, in_start_y = '0, in_start_z = '0;
  coord_t in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit, out_coplanar;
  logic signed [spi_pkg::PT_W-1:0] out_point_x, out_point_y, out_point_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spi_pkg::CFG_IDX_W-1:0] cfg_index = spi_pkg::CFG_ORIGIN;
  logic [spi_pkg::CFG_W-1:0] cfg_data = '0;

  // shadow of the plane registers
  logic [spi_pkg::CFG_W-1:0] corner_reg = '0, edge_a_reg = '0, edge_b_reg = '0;

  isect_t pending_q[$];
  int errors = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  segment_parallelogram_intersect_top #(.COORD_BITS(COORD_W)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // handshake signals are stable at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    isect_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result transfer hit=%0b", $time, out_hit);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_hit !== want.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, want.hit, out_hit);
          errors++;
        end
        if (out_coplanar !== want.cop) begin
          $display("%0t: coplanar exp %0b got %0b", $time, want.cop, out_coplanar);
          errors++;
        end
        if (out_point_x !== want.px) begin
          $display("%0t: point_x exp %0d got %0d", $time, want.px, out_point_x);
          errors++;
        end
        if (out_point_y !== want.py) begin
          $display("%0t: point_y exp %0d got %0d", $time, want.py, out_point_y);
          errors++;
        end
        if (out_point_z !== want.pz) begin
          $display("%0t: point_z exp %0d got %0d", $time, want.pz, out_point_z);
          errors++;
        end
      end
    end
  end

  // p . (q x s)
  function automatic wide_t triple(longint p0, longint p1, longint p2, longint q0,
                                   longint q1, longint q2, longint s0, longint s1,
                                   longint s2);
    longint cx, cy, cz;
    wide_t acc;
    cx = q1 * s2 - q2 * s1;
    cy = q2 * s0 - q0 * s2;
    cz = q0 * s1 - q1 * s0;
    acc = wide_t'(p0) * wide_t'(cx);
    acc = acc + wide_t'(p1) * wide_t'(cy);
    return acc + wide_t'(p2) * wide_t'(cz);
  endfunction

  function automatic logic signed [spi_pkg::PT_W-1:0] axis_point(longint s, longint dv,
                                                                 wide_t nt, wide_t den);
    wide_t q;
    q = (wide_t'(s) * den + wide_t'(dv) * nt) / den;
    if (q > spi_pkg::PT_MAX) q = spi_pkg::PT_MAX;
    if (q < spi_pkg::PT_MIN) q = spi_pkg::PT_MIN;
    return q[spi_pkg::PT_W-1:0];
  endfunction

  function automatic isect_t crossing_point(coord_t sx, coord_t sy, coord_t sz, coord_t ex,
                                            coord_t ey, coord_t ez);
    longint s[3], d[3], r[3], a[3], b[3];
    wide_t den, nt, nu, nv;
    isect_t res;
    s[0] = sx; s[1] = sy; s[2] = sz;
    d[0] = longint'(ex) - sx; d[1] = longint'(ey) - sy; d[2] = longint'(ez) - sz;
    for (int k = 0; k < 3; k++) begin
      a[k] = coord_t'(edge_a_reg[k*COORD_W +: COORD_W]);
      b[k] = coord_t'(edge_b_reg[k*COORD_W +: COORD_W]);
      r[k] = longint'(coord_t'(corner_reg[k*COORD_W +: COORD_W])) - s[k];
    end
    res = '{1'b0, 1'b0, '0, '0, '0};
    den = triple(d[0], d[1], d[2], a[0], a[1], a[2], b[0], b[1], b[2]);
    nt = triple(r[0], r[1], r[2], a[0], a[1], a[2], b[0], b[1], b[2]);
    if (den == 0) begin
      if (nt == 0) res = '{1'b1, 1'b1, sx, sy, sz};
      return res;
    end
    nu = -triple(d[0], d[1], d[2], r[0], r[1], r[2], b[0], b[1], b[2]);
    nv = -triple(d[0], d[1], d[2], a[0], a[1], a[2], r[0], r[1], r[2]);
    if (den < 0) begin
      den = -den; nt = -nt; nu = -nu; nv = -nv;
    end
    if (nt >= 0 && nt <= den && nu >= 0 && nu <= den && nv >= 0 && nv <= den) begin
      res.hit = 1'b1;
      res.px = axis_point(s[0], d[0], nt, den);
      res.py = axis_point(s[1], d[1], nt, den);
      res.pz = axis_point(s[2], d[2], nt, den);
    end
    return res;
  endfunction

  task automatic send_segment(coord_t sx, coord_t sy, coord_t sz, coord_t ex, coord_t ey,
                              coord_t ez);
    logic taken;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx; in_start_y <= sy; in_start_z <= sz;
    in_end_x <= ex; in_end_y <= ey; in_end_z <= ez;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pending_q.push_back(crossing_point(sx, sy, sz, ex, ey, ez));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [spi_pkg::CFG_IDX_W-1:0] idx,
                           logic [spi_pkg::CFG_W-1:0] val);
    logic taken;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    case (idx)
      spi_pkg::CFG_ORIGIN:   corner_reg = val;
      spi_pkg::CFG_EDGE_ONE: edge_a_reg = val;
      spi_pkg::CFG_EDGE_TWO: edge_b_reg = val;
      default: ;
    endcase
  endtask

  function automatic logic [spi_pkg::CFG_W-1:0] pack3(coord_t x, coord_t y, coord_t z);
    return {z, y, x};
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(7))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      2: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t span(int lim);
    return coord_t'($signed($urandom_range(2 * lim)) - lim);
  endfunction

  task automatic test_reset_plane();
    // all-zero registers form a degenerate plane: every segment is coplanar
    send_segment(16'sd100, -16'sd200, 16'sd300, 16'sd5, 16'sd6, 16'sd7);
    send_segment(coord_t'(-32768), coord_t'(32767), '0, coord_t'(32767), '0, '0);
  endtask

  task automatic test_unit_square();
    write_reg(spi_pkg::CFG_ORIGIN, pack3(0, 0, 0));
    write_reg(spi_pkg::CFG_EDGE_ONE, pack3(256, 0, 0));
    write_reg(spi_pkg::CFG_EDGE_TWO, pack3(0, 256, 0));
    send_segment(128, 128, -256, 128, 128, 256);      // clean hit at center
    send_segment(100, 50, -300, 60, 90, 500);         // slanted hit
    send_segment(-100, -50, -300, -60, -90, 500);     // slanted miss on negative side
    send_segment(400, 128, -256, 400, 128, 256);      // u out of range
    send_segment(128, 400, -256, 128, 400, 256);      // v out of range
    send_segment(128, 128, 10, 128, 128, 256);        // t < 0
    send_segment(128, 128, -256, 128, 128, -10);      // t > 1
    send_segment(128, 128, 0, 128, 128, 256);         // start on plane
    send_segment(128, 128, -256, 128, 128, 0);        // end on plane
    send_segment(0, 0, -256, 256, 256, 256);          // diagonal across the square, hits at center
    send_segment(50, 60, 0, 900, -700, 0);            // in plane
    send_segment(50, 60, 40, 900, -700, 40);          // parallel off plane
    send_segment(7, 8, 9, 7, 8, 9);                   // zero length off plane
    send_segment(7, 8, 0, 7, 8, 0);                   // zero length in plane
    send_segment(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768),
                 coord_t'(32767), coord_t'(32767), coord_t'(32767));
    send_segment(coord_t'(32767), coord_t'(32767), coord_t'(-32768),
                 coord_t'(-32768), coord_t'(-32768), coord_t'(32767));
    send_segment(10, 10, coord_t'(-32768), 10, 10, coord_t'(32767));
  endtask

  task automatic test_degenerate();
    write_reg(spi_pkg::CFG_EDGE_TWO, pack3(512, 0, 0));   // parallel edges
    send_segment(128, 128, -256, 128, 128, 256);
    send_segment(1, 2, 3, 4, 5, 6);
    write_reg(CFG_UNMAPPED, 48'hDEAD_BEEF_1234);          // unmapped index, ignored
    write_reg(spi_pkg::CFG_EDGE_TWO, pack3(0, 256, 0));
    send_segment(128, 128, -256, 128, 128, 256);
  endtask

  task automatic random_plane();
    if ($urandom_range(4) == 0) begin
      write_reg(spi_pkg::CFG_ORIGIN, spi_pkg::CFG_W'({$urandom, $urandom}));
      write_reg(spi_pkg::CFG_EDGE_ONE, spi_pkg::CFG_W'({$urandom, $urandom}));
      write_reg(spi_pkg::CFG_EDGE_TWO, spi_pkg::CFG_W'({$urandom, $urandom}));
    end else begin
      write_reg(spi_pkg::CFG_ORIGIN, pack3(span(4096), span(4096), span(4096)));
      write_reg(spi_pkg::CFG_EDGE_ONE, pack3(span(2048), span(2048), span(2048)));
      write_reg(spi_pkg::CFG_EDGE_TWO, pack3(span(2048), span(2048), span(2048)));
    end
  endtask

  task automatic random_segments(int count);
    longint o[3], a[3], b[3], p[3], dv[3], sv[3], ev[3];
    int u, v, back, fwd, kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      for (int k = 0; k < 3; k++) begin
        o[k] = coord_t'(corner_reg[k*COORD_W +: COORD_W]);
        a[k] = coord_t'(edge_a_reg[k*COORD_W +: COORD_W]);
        b[k] = coord_t'(edge_b_reg[k*COORD_W +: COORD_W]);
      end
      u = $urandom_range(300);
      v = $urandom_range(300);
      back = $urandom_range(10);
      fwd = $urandom_range(10);
      for (int k = 0; k < 3; k++) begin
        p[k] = o[k] + (a[k] * u + b[k] * v) / 256;
        dv[k] = (kind == 7) ? a[k] : span(4096);
        sv[k] = p[k] - dv[k] * back / 8;
        ev[k] = p[k] + dv[k] * fwd / 8;
        if (sv[k] > 32767) sv[k] = 32767;
        if (sv[k] < -32768) sv[k] = -32768;
        if (ev[k] > 32767) ev[k] = 32767;
        if (ev[k] < -32768) ev[k] = -32768;
      end
      if (kind <= 7)
        send_segment(coord_t'(sv[0]), coord_t'(sv[1]), coord_t'(sv[2]),
                     coord_t'(ev[0]), coord_t'(ev[1]), coord_t'(ev[2]));
      else
        send_segment(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                     any_coord());
    end
  endtask

  task automatic test_random(int sender_idle, int receiver_stall);
    send_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int ph = 0; ph < 3; ph++) begin
      random_plane();
      random_segments(85);
    end
  endtask

  task automatic test_extreme_planes();
    write_reg(spi_pkg::CFG_ORIGIN, '1);
    write_reg(spi_pkg::CFG_EDGE_ONE, pack3(coord_t'(32767), coord_t'(-32768), 0));
    write_reg(spi_pkg::CFG_EDGE_TWO, pack3(0, coord_t'(32767), coord_t'(-32768)));
    random_segments(40);
    write_reg(spi_pkg::CFG_ORIGIN,
              pack3(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768)));
    write_reg(spi_pkg::CFG_EDGE_ONE, '1);
    write_reg(spi_pkg::CFG_EDGE_TWO,
              pack3(coord_t'(32767), coord_t'(32767), coord_t'(-32768)));
    random_segments(40);
  endtask

  task automatic test_backpressure();
    send_pct = 0;
    stall_pct = 0;
    random_plane();
    hold_req = 400;
    random_segments(80);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_plane();
    test_unit_square();
    test_degenerate();
    test_random(0, 0);
    test_random(78, 0);
    test_random(0, 78);
    test_random(30, 30);
    test_extreme_planes();
    test_backpressure();
    drain_results();
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
